@@ rtl/core/amt_pkg.sv @@
// Shared types and constants of the adjacency matrix to triples unit.
`timescale 1ns / 1ps
package amt_pkg;

	localparam int MAX_VERTICES_DEF = 8;
	localparam int COUNT_W = 4;   // vertex_count and vertex field width
	localparam int IDX_W   = 3;   // row/column result width
	localparam int WGT_W   = 16;  // edge weight width

	typedef enum logic [2:0] {
		ST_WRITTEN = 3'd0,
		ST_RANGE   = 3'd1,
		ST_SELF    = 3'd2,
		ST_TRIPLE  = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_SCAN  = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_VERTEX_COUNT  = 1'b0,
		REG_DIRECTED_MODE = 1'b1
	} reg_index_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the item fields
		logic do_write;   // check and store the captured edge
		logic scan_init;  // reset walk counters, drop pending triple
		logic scan_read;  // read current pair, advance walk
		logic flush;      // emit final result of a scan
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;     // current pair is the last of the triangle
		logic few_vertices;  // fewer than two vertices: nothing to walk
	} dp_stat_t;

endpackage

@@ rtl/core/amt_ctrl.sv @@
// Controller state machine of the adjacency matrix to triples unit.
`timescale 1ns / 1ps
module amt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               opcode,
	input  amt_pkg::dp_stat_t  stat,
	output logic               busy,
	output amt_pkg::dp_cmd_t   cmd
);
	import amt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WRITE = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (opcode == OP_WRITE) begin
						state_d = S_WRITE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d = stat.few_vertices ? S_FLUSH : S_SCAN;
					end
				end
			end
			S_WRITE: begin
				cmd.do_write = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_read = 1'b1;
				if (stat.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ rtl/core/amt_datapath.sv @@
// Datapath: weight memory, edge checks, triangle walk and result registers.
`timescale 1ns / 1ps
module amt_datapath #(
	parameter int MAX_VERTICES = amt_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  amt_pkg::dp_cmd_t                    cmd,
	output amt_pkg::dp_stat_t                   stat,
	input  logic [amt_pkg::COUNT_W-1:0]         vertex_count,
	input  logic                                directed_mode,
	input  logic [amt_pkg::COUNT_W-1:0]         from_vertex,
	input  logic [amt_pkg::COUNT_W-1:0]         to_vertex,
	input  logic signed [amt_pkg::WGT_W-1:0]    edge_weight,
	output logic                                result_valid,
	output logic [2:0]                          status,
	output logic [amt_pkg::IDX_W-1:0]           row_vertex,
	output logic [amt_pkg::IDX_W-1:0]           column_vertex,
	output logic signed [amt_pkg::WGT_W-1:0]    triple_weight,
	output logic                                last_result
);
	import amt_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0]      ROW_STRIDE = AW'(MAX_VERTICES);
	localparam logic [COUNT_W-1:0] MAX_CNT    = COUNT_W'(MAX_VERTICES);

	// active vertex count, clamped to the built size
	logic [COUNT_W-1:0] n_act, n_m1, n_m2;
	assign n_act = (vertex_count > MAX_CNT) ? MAX_CNT : vertex_count;
	assign n_m1  = n_act - 1'b1;
	assign n_m2  = n_act - 2'd2;

	// captured item
	logic [COUNT_W-1:0]      from_q, to_q;
	logic signed [WGT_W-1:0] weight_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			from_q   <= from_vertex;
			to_q     <= to_vertex;
			weight_q <= edge_weight;
		end
	end

	// edge checks; only the upper triangle is ever scanned, so only the
	// upper-triangle copy of an edge is stored
	logic          oor, self_loop, fwd, wr_en;
	logic [VW-1:0] wr_row, wr_col;
	logic [AW-1:0] wr_addr;

	assign oor       = (from_q >= n_act) || (to_q >= n_act);
	assign self_loop = (from_q == to_q);
	assign fwd       = (from_q < to_q);
	assign wr_en     = cmd.do_write && !oor && !self_loop && (fwd || !directed_mode);
	assign wr_row    = fwd ? from_q[VW-1:0] : to_q[VW-1:0];
	assign wr_col    = fwd ? to_q[VW-1:0]   : from_q[VW-1:0];
	assign wr_addr   = AW'(wr_row) * ROW_STRIDE + AW'(wr_col);

	// triangle walk counters
	logic [VW-1:0] row_q, col_q;
	logic [AW-1:0] rd_addr;

	assign rd_addr = AW'(row_q) * ROW_STRIDE + AW'(col_q);
	assign stat.scan_last    = (COUNT_W'(row_q) == n_m2) && (COUNT_W'(col_q) == n_m1);
	assign stat.few_vertices = (n_act < 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.scan_init) begin
			row_q <= '0;
			col_q <= VW'(1);
		end else if (cmd.scan_read) begin
			if (COUNT_W'(col_q) == n_m1) begin
				row_q <= row_q + 1'b1;
				col_q <= VW'(row_q + 2);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// weight memory; valid bits stand for the all-zero reset contents
	logic signed [WGT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic signed [WGT_W-1:0] rd_data_s1;
	logic                    rd_vld_s1;
	logic [VW-1:0]           rd_row_s1, rd_col_s1;
	logic                    rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= weight_q;
		if (cmd.scan_read) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr];
			rd_row_s1  <= row_q;
			rd_col_s1  <= col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			rd_s1 <= cmd.scan_read;
		end
	end

	logic hit_s1;
	assign hit_s1 = rd_s1 && rd_vld_s1 && (rd_data_s1 != '0);

	// one triple held back so the final one can carry the last mark
	logic                    pend_vld_q;
	logic [VW-1:0]           pend_row_q, pend_col_q;
	logic signed [WGT_W-1:0] pend_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_vld_q <= 1'b0;
		else if (cmd.scan_init || cmd.flush)
			pend_vld_q <= 1'b0;
		else if (hit_s1)
			pend_vld_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (hit_s1) begin
			pend_row_q <= rd_row_s1;
			pend_col_q <= rd_col_s1;
			pend_w_q   <= rd_data_s1;
		end
	end

	// result registers
	logic                    res_vld_q;
	status_t                 res_st_q;
	logic [IDX_W-1:0]        res_row_q, res_col_q;
	logic signed [WGT_W-1:0] res_w_q;
	logic                    res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else
			res_vld_q <= cmd.do_write || cmd.flush || (hit_s1 && pend_vld_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.do_write) begin
			res_st_q   <= oor ? ST_RANGE : (self_loop ? ST_SELF : ST_WRITTEN);
			res_row_q  <= '0;
			res_col_q  <= '0;
			res_w_q    <= '0;
			res_last_q <= 1'b1;
		end else if (cmd.flush) begin
			res_last_q <= 1'b1;
			if (pend_vld_q) begin
				res_st_q  <= ST_TRIPLE;
				res_row_q <= IDX_W'(pend_row_q);
				res_col_q <= IDX_W'(pend_col_q);
				res_w_q   <= pend_w_q;
			end else begin
				res_st_q  <= ST_EMPTY;
				res_row_q <= '0;
				res_col_q <= '0;
				res_w_q   <= '0;
			end
		end else if (hit_s1 && pend_vld_q) begin
			res_st_q   <= ST_TRIPLE;
			res_row_q  <= IDX_W'(pend_row_q);
			res_col_q  <= IDX_W'(pend_col_q);
			res_w_q    <= pend_w_q;
			res_last_q <= 1'b0;
		end
	end

	assign result_valid  = res_vld_q;
	assign status        = res_st_q;
	assign row_vertex    = res_row_q;
	assign column_vertex = res_col_q;
	assign triple_weight = res_w_q;
	assign last_result   = res_last_q;

endmodule

@@ rtl/core/adjacency_matrix_to_triples_unit.sv @@
// Top level of the adjacency matrix to triples unit.
`timescale 1ns / 1ps
// Keeps a weighted adjacency matrix and lists its upper triangle as triples.
// Input: a transaction is taken at a rising edge with start high and busy low.
//   opcode 0 writes an edge (from_vertex, to_vertex, edge_weight); opcode 1
//   scans the matrix.
// Output: each result is shown for exactly one cycle with result_valid high;
//   the receiver cannot stall, so results are never held back or dropped.
//   last_result marks the final result of a transaction.
// Edge write: one result in the cycle after the work state; busy is
//   high for one cycle, so a new write can follow as soon as busy drops.
// Scan: the walk reads one entry per cycle through the single memory read
//   port, n*(n-1)/2 reads for n active vertices, then passes through the
//   drain and flush states (only the flush state for n below 2).
//   Triples come out in row, column order; an empty scan gives one result
//   with status 4.
// Config: cfg_write/cfg_index/cfg_data, taken at any edge with cfg_write
//   high; write only while idle.
// Reset: clears the control state, the configuration to 8 vertices and
//   mirrored mode, and the per-entry valid bits that make the whole matrix
//   read as zero at once; no clearing pass is needed.
module adjacency_matrix_to_triples_unit #(
	parameter int MAX_VERTICES = amt_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [amt_pkg::COUNT_W-1:0]       cfg_data,
	// input transaction
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [amt_pkg::COUNT_W-1:0]       from_vertex,
	input  logic [amt_pkg::COUNT_W-1:0]       to_vertex,
	input  logic signed [amt_pkg::WGT_W-1:0]  edge_weight,
	// result transaction
	output logic                              result_valid,
	output logic [2:0]                        status,
	output logic [amt_pkg::IDX_W-1:0]         row_vertex,
	output logic [amt_pkg::IDX_W-1:0]         column_vertex,
	output logic signed [amt_pkg::WGT_W-1:0]  triple_weight,
	output logic                              last_result
);
	import amt_pkg::*;

	// configuration registers
	logic [COUNT_W-1:0] vertex_count_q;
	logic               directed_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= COUNT_W'(8);
			directed_mode_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VERTEX_COUNT:  vertex_count_q  <= cfg_data;
				REG_DIRECTED_MODE: directed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing: idle, edge write, walk, drain of the read stage, flush
	amt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage, checks, walk counters and result registers
	amt_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.vertex_count  (vertex_count_q),
		.directed_mode (directed_mode_q),
		.from_vertex   (from_vertex),
		.to_vertex     (to_vertex),
		.edge_weight   (edge_weight),
		.result_valid  (result_valid),
		.status        (status),
		.row_vertex    (row_vertex),
		.column_vertex (column_vertex),
		.triple_weight (triple_weight),
		.last_result   (last_result)
	);

endmodule
